@@ design/sbsm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbsm_pkg
// Shared types and constants of the serial bank switch mapper.
// ----------------------------------------------------------------------------
package sbsm_pkg;

   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned BANK_W   = 6;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned SHIFT_W  = 5;
   localparam int unsigned SCOUNT_W = 3;

   localparam logic [COUNT_W-1:0]  LARGE_ROM_BANKS   = 7'd32;
   localparam logic [COUNT_W-1:0]  BANK_COUNT_RESET  = 7'd8;
   localparam logic [SCOUNT_W-1:0] SHIFT_LAST        = 3'd4;
   localparam logic [SHIFT_W-1:0]  CLEAR_CONTROL_SET = 5'b01100;

   // control register bits and the data clear bit
   localparam int unsigned CTRL_CHR_4K   = 4;
   localparam int unsigned CTRL_PRG_16K  = 3;
   localparam int unsigned CTRL_PRG_LOW  = 2;
   localparam int unsigned DATA_CLEAR    = 7;

   typedef enum logic [2:0] {
      TGT_CONTROL   = 3'd0,
      TGT_CHAR_LOW  = 3'd1,
      TGT_CHAR_HIGH = 3'd2,
      TGT_PROGRAM   = 3'd3
   } sbsm_target_type;

   typedef struct packed {
      logic              fire;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] data;
   } sbsm_step_type;

   typedef struct packed {
      logic [BANK_W-1:0] program_bank_first;
      logic [BANK_W-1:0] program_bank_second;
      logic [BANK_W-1:0] char_bank_first;
      logic [BANK_W-1:0] char_bank_second;
      logic [1:0]        mirror_mode;
   } sbsm_banks_type;

endpackage
`default_nettype wire

@@ design/sbsm_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbsm channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface sbsm_req_if
   import sbsm_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] write_address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output write_address, output write_data, input ready);
   modport sink   (input valid, input write_address, input write_data, output ready);
endinterface

interface sbsm_rsp_if
   import sbsm_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BANK_W-1:0] program_bank_first;
   logic [BANK_W-1:0] program_bank_second;
   logic [BANK_W-1:0] char_bank_first;
   logic [BANK_W-1:0] char_bank_second;
   logic [1:0]        mirror_mode;

   modport source (output valid, output program_bank_first, output program_bank_second,
                   output char_bank_first, output char_bank_second, output mirror_mode,
                   input ready);
   modport sink   (input valid, input program_bank_first, input program_bank_second,
                   input char_bank_first, input char_bank_second, input mirror_mode,
                   output ready);
endinterface

interface sbsm_csr_if
   import sbsm_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] program_bank_count;

   modport source (output valid, output program_bank_count, input ready);
   modport sink   (input valid, input program_bank_count, output ready);
endinterface
`default_nettype wire

@@ design/serial_bank_switch_mapper.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper
// Serial-loaded bank switch mapper: CPU write words in, slot selections out.
//
// req_chan carries one CPU write word (address, data). Each accepted word
// gives exactly one word on rsp_chan with the program and character slot
// banks and the mirroring mode after that write. csr_chan writes the
// program bank count; it is always ready and may be written only while no
// word is in flight.
// A word accepted on req_chan passes the input register, then the result
// register, to rsp_chan. Throughput without stalls: one word per cycle,
// set by the combinational update between the two registers.
// Reset clears the shifter and mapper registers, sets the bank count to 8,
// the second program slot to the last bank and empties both registers.
// When rsp_chan stalls, the result register holds, the input register
// still takes one more word, then req_chan.ready drops until rsp moves.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper
   import sbsm_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   sbsm_req_if.sink   req_chan,
   sbsm_rsp_if.source rsp_chan,
   sbsm_csr_if.sink   csr_chan
);

   logic              in_valid_ff,  in_valid_in;
   logic [ADDR_W-1:0] in_addr_ff,   in_addr_in;
   logic [DATA_W-1:0] in_data_ff,   in_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sbsm_banks_type    rsp_ff,       rsp_in;

   logic              advance;
   logic              req_fire;
   sbsm_step_type     step;
   sbsm_banks_type    banks_next;

   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign step.fire    = in_valid_ff && advance;
   assign step.address = in_addr_ff;
   assign step.data    = in_data_ff;

   sbsm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cfg_write  (csr_chan.valid),
      .cfg_data   (csr_chan.program_bank_count),
      .banks_next (banks_next)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_addr_in   = in_addr_ff;
      in_data_in   = in_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            rsp_in = banks_next;
         end
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_addr_in  = req_chan.write_address;
         in_data_in  = req_chan.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_addr_ff <= in_addr_in;
      in_data_ff <= in_data_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.program_bank_first  = rsp_ff.program_bank_first;
   assign rsp_chan.program_bank_second = rsp_ff.program_bank_second;
   assign rsp_chan.char_bank_first     = rsp_ff.char_bank_first;
   assign rsp_chan.char_bank_second    = rsp_ff.char_bank_second;
   assign rsp_chan.mirror_mode         = rsp_ff.mirror_mode;

   a_word_to_result: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_addr_ff) && $stable(in_data_ff))
      else $error("input word lost during stall");

   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid_ff && rsp_valid_ff)
      else $error("ready low with free stage");

endmodule
`default_nettype wire

@@ design/sbsm_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbsm_core
// Serial shifter, mapper registers and bank slot update for one write.
// ----------------------------------------------------------------------------
module sbsm_core
   import sbsm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sbsm_step_type        step,
   input  wire logic                 cfg_write,
   input  wire logic [COUNT_W-1:0]   cfg_data,
   output sbsm_banks_type            banks_next
);

   logic [COUNT_W-1:0]  bank_count_ff,  bank_count_in;
   logic [SCOUNT_W-1:0] shift_count_ff, shift_count_in;
   logic [SHIFT_W-1:0]  shift_value_ff, shift_value_in;
   logic [SHIFT_W-1:0]  control_ff,     control_in;
   logic [3:0]          prg_select_ff,  prg_select_in;
   logic                outer_ff,       outer_in;
   logic [BANK_W-1:0]   prg0_ff, prg0_in, prg1_ff, prg1_in;
   logic [BANK_W-1:0]   chr0_ff, chr0_in, chr1_ff, chr1_in;

   sbsm_target_type     target;
   logic [SHIFT_W-1:0]  shifted;
   logic                large_mode;
   logic [BANK_W-1:0]   char_bank;
   logic [BANK_W-1:0]   prg_bank;
   logic [BANK_W-1:0]   prg_even;
   logic [COUNT_W-1:0]  last_bank;

   assign target     = sbsm_target_type'({~step.address[ADDR_W-1], step.address[14:13]});
   assign large_mode = (bank_count_ff >= LARGE_ROM_BANKS);
   assign shifted    = shift_value_ff | (SHIFT_W'(step.data[0]) << shift_count_ff);
   assign char_bank  = large_mode ? BANK_W'(shifted[0]) : BANK_W'(shifted);
   assign last_bank  = bank_count_ff - 7'd1;

   always_comb begin
      bank_count_in  = cfg_write ? cfg_data : bank_count_ff;
      shift_count_in = shift_count_ff;
      shift_value_in = shift_value_ff;
      control_in     = control_ff;
      prg_select_in  = prg_select_ff;
      outer_in       = outer_ff;
      chr0_in        = chr0_ff;
      chr1_in        = chr1_ff;

      if (step.fire) begin
         if (step.data[DATA_CLEAR]) begin
            shift_count_in = '0;
            shift_value_in = '0;
            control_in     = control_ff | CLEAR_CONTROL_SET;
            outer_in       = 1'b0;
         end else if (shift_count_ff == SHIFT_LAST) begin
            shift_count_in = '0;
            shift_value_in = '0;
            unique case (target)
               TGT_CONTROL: begin
                  control_in = shifted;
               end
               TGT_CHAR_LOW: begin
                  if (large_mode) begin
                     outer_in = shifted[4];
                  end
                  if (control_ff[CTRL_CHR_4K]) begin
                     chr0_in = char_bank;
                  end else begin
                     chr0_in = {char_bank[BANK_W-1:1], 1'b0};
                     chr1_in = {char_bank[BANK_W-1:1], 1'b0} + 6'd1;
                  end
               end
               TGT_CHAR_HIGH: begin
                  if (control_ff[CTRL_CHR_4K]) begin
                     chr1_in = char_bank;
                     if (large_mode) begin
                        outer_in = shifted[4];
                     end
                  end
               end
               TGT_PROGRAM: begin
                  prg_select_in = shifted[3:0];
               end
               default: begin
               end
            endcase
         end else begin
            shift_count_in = shift_count_ff + 3'd1;
            shift_value_in = shifted;
         end
      end
   end

   // program slot recompute on every clear or commit
   assign prg_bank = {1'b0, outer_in, prg_select_in};
   assign prg_even = {prg_bank[BANK_W-1:1], 1'b0};

   always_comb begin
      prg0_in = prg0_ff;
      prg1_in = prg1_ff;
      if (step.fire && (step.data[DATA_CLEAR] || shift_count_ff == SHIFT_LAST)) begin
         priority if (control_in[CTRL_PRG_16K] && control_in[CTRL_PRG_LOW]) begin
            prg0_in = prg_bank;
            prg1_in = {1'b0, outer_in, last_bank[3:0]};
         end else if (control_in[CTRL_PRG_16K]) begin
            prg0_in = {1'b0, outer_in, 4'd0};
            prg1_in = prg_bank;
         end else begin
            prg0_in = prg_even;
            prg1_in = prg_even + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_count_ff  <= BANK_COUNT_RESET;
         shift_count_ff <= '0;
         shift_value_ff <= '0;
         control_ff     <= '0;
         prg_select_ff  <= '0;
         outer_ff       <= 1'b0;
         prg0_ff        <= '0;
         prg1_ff        <= BANK_W'(BANK_COUNT_RESET - 7'd1);
         chr0_ff        <= '0;
         chr1_ff        <= '0;
      end else begin
         bank_count_ff  <= bank_count_in;
         shift_count_ff <= shift_count_in;
         shift_value_ff <= shift_value_in;
         control_ff     <= control_in;
         prg_select_ff  <= prg_select_in;
         outer_ff       <= outer_in;
         prg0_ff        <= prg0_in;
         prg1_ff        <= prg1_in;
         chr0_ff        <= chr0_in;
         chr1_ff        <= chr1_in;
      end
   end

   assign banks_next.program_bank_first  = prg0_in;
   assign banks_next.program_bank_second = prg1_in;
   assign banks_next.char_bank_first     = chr0_in;
   assign banks_next.char_bank_second    = chr1_in;
   assign banks_next.mirror_mode         = control_in[1:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      shift_count_ff <= SHIFT_LAST)
      else $error("shift count out of range");

   a_clear_word: assert property (@(posedge clock) disable iff (reset)
      step.fire && step.data[DATA_CLEAR] |=>
         shift_count_ff == '0 && control_ff[3:2] == 2'b11 && !outer_ff)
      else $error("clear word did not reset shifter");

   a_commit_empties: assert property (@(posedge clock) disable iff (reset)
      step.fire && !step.data[DATA_CLEAR] && shift_count_ff == SHIFT_LAST |=>
         shift_value_ff == '0 && shift_count_ff == '0)
      else $error("fifth bit did not empty shifter");

endmodule
`default_nettype wire
